### rtl/tps_pkg.sv
// tone pattern sequencer package: item types, action codes and pattern tables
package tps_pkg;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_PLAY = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  localparam logic [2:0] ERROR_ALARM_PAT = 3'd4;
  localparam logic [2:0] NUM_PATTERNS    = 3'd6;
  localparam logic [9:0] ELAPSED_MAX     = 10'd1023;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] pattern;
  } item_t;

  typedef struct packed {
    logic [11:0] tone_hz;
    logic        playing;
  } result_t;

  // number of steps in each pattern
  function automatic logic [2:0] pat_len(input logic [2:0] p);
    logic [2:0] r;
    case (p)
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd3;
      3'd4:    r = 3'd5;
      3'd5:    r = 3'd3;
      3'd6:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // first step of each pattern in the step table
  function automatic logic [4:0] pat_off(input logic [2:0] p);
    logic [4:0] r;
    case (p)
      3'd1:    r = 5'd0;
      3'd2:    r = 5'd1;
      3'd3:    r = 5'd4;
      3'd4:    r = 5'd7;
      3'd5:    r = 5'd12;
      3'd6:    r = 5'd15;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] step_freq(input logic [4:0] i);
    logic [11:0] r;
    case (i)
      5'd0:    r = 12'd4000;
      5'd1:    r = 12'd800;
      5'd2:    r = 12'd1000;
      5'd3:    r = 12'd1200;
      5'd4:    r = 12'd1000;
      5'd5:    r = 12'd0;
      5'd6:    r = 12'd1000;
      5'd7:    r = 12'd800;
      5'd8:    r = 12'd0;
      5'd9:    r = 12'd800;
      5'd10:   r = 12'd0;
      5'd11:   r = 12'd800;
      5'd12:   r = 12'd600;
      5'd13:   r = 12'd900;
      5'd14:   r = 12'd600;
      5'd15:   r = 12'd500;
      5'd16:   r = 12'd0;
      5'd17:   r = 12'd500;
      5'd18:   r = 12'd0;
      default: r = 12'd0;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] step_ms(input logic [4:0] i);
    logic [9:0] r;
    case (i)
      5'd0:    r = 10'd30;
      5'd1:    r = 10'd100;
      5'd2:    r = 10'd100;
      5'd3:    r = 10'd150;
      5'd4:    r = 10'd100;
      5'd5:    r = 10'd80;
      5'd6:    r = 10'd100;
      5'd7:    r = 10'd200;
      5'd8:    r = 10'd200;
      5'd9:    r = 10'd200;
      5'd10:   r = 10'd200;
      5'd11:   r = 10'd200;
      5'd12:   r = 10'd150;
      5'd13:   r = 10'd150;
      5'd14:   r = 10'd150;
      5'd15:   r = 10'd300;
      5'd16:   r = 10'd700;
      5'd17:   r = 10'd300;
      5'd18:   r = 10'd700;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/tps_if.sv
// valid/ready channel interfaces for request and result items
interface tps_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] pattern;

  modport source (output valid, output action, output pattern, input ready);
  modport sink (input valid, input action, input pattern, output ready);
endinterface

interface tps_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] tone_hz;
  logic        playing;

  modport source (output valid, output tone_hz, output playing, input ready);
  modport sink (input valid, input tone_hz, input playing, output ready);
endinterface

### rtl/tone_pattern_sequencer.sv
// tone pattern sequencer top level: input register, sequencer, result register
// an accepted item is registered in the input register, then its result in the result register
// throughput: one item per cycle while the result is not stalled; ready stays high while the result register drains
// one input register and one result register, the sequencer state sits between them
// reset clears the pattern state to idle, empties both registers, sets sound_enable to 1
// there is no clearing pass; items are taken from the first cycle after reset
module tone_pattern_sequencer #(
  parameter int PATTERN_SLOTS = 7
) (
  input logic       clk,
  input logic       rst,
  input logic       cfg_wr_en,
  input logic       cfg_wr_data,
  tps_req_if.sink   req,
  tps_rsp_if.source rsp
);

  logic             sound_enable;
  logic             in_valid;
  tps_pkg::item_t   in_item;
  logic             out_valid;
  tps_pkg::result_t out_result;
  tps_pkg::result_t seq_result;
  logic             out_adv;
  logic             fire;

  assign out_adv   = !out_valid || rsp.ready;
  assign fire      = in_valid && out_adv;
  assign req.ready = !in_valid || out_adv;

  assign rsp.valid   = out_valid;
  assign rsp.tone_hz = out_result.tone_hz;
  assign rsp.playing = out_result.playing;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      sound_enable <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item.action  <= req.action;
      in_item.pattern <= req.pattern;
    end
  end

  tps_seq #(
    .PATTERN_SLOTS(PATTERN_SLOTS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .fire(fire),
    .sound_enable(sound_enable),
    .item(in_item),
    .result(seq_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= seq_result;
    end
  end

endmodule

### rtl/tps_seq.sv
// sequencer state registers and per-item next state and tone lookup
module tps_seq #(
  parameter int PATTERN_SLOTS = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             sound_enable,
  input  tps_pkg::item_t   item,
  output tps_pkg::result_t result
);

  localparam logic [3:0] SLOTS = 4'(PATTERN_SLOTS);

  logic       busy;
  logic [2:0] current_pattern;
  logic [2:0] step_number;
  logic [9:0] step_elapsed_ms;

  logic       busy_mid;
  logic [2:0] pattern_mid;
  logic [2:0] step_mid;
  logic [9:0] elapsed_mid;

  logic       busy_next;
  logic [2:0] current_pattern_next;
  logic [2:0] step_number_next;
  logic [9:0] step_elapsed_ms_next;

  function automatic logic pat_ok(input logic [2:0] p);
    return (p != 3'd0) && (p <= tps_pkg::NUM_PATTERNS) && ({1'b0, p} < SLOTS);
  endfunction

  // apply the item
  always_comb begin
    logic [9:0] el_inc;
    logic [3:0] sn_inc;
    logic [4:0] idx;
    busy_mid    = busy;
    pattern_mid = current_pattern;
    step_mid    = step_number;
    elapsed_mid = step_elapsed_ms;
    el_inc = (step_elapsed_ms < tps_pkg::ELAPSED_MAX) ? step_elapsed_ms + 10'd1
                                                     : step_elapsed_ms;
    sn_inc = {1'b0, step_number} + 4'd1;
    idx    = tps_pkg::pat_off(current_pattern) + {2'b00, step_number};
    case (item.action)
      tps_pkg::ACT_PLAY: begin
        if ((sound_enable || item.pattern == tps_pkg::ERROR_ALARM_PAT) &&
            pat_ok(item.pattern)) begin
          busy_mid    = 1'b1;
          pattern_mid = item.pattern;
          step_mid    = 3'd0;
          elapsed_mid = 10'd0;
        end
      end
      tps_pkg::ACT_STOP: begin
        busy_mid    = 1'b0;
        pattern_mid = 3'd0;
        step_mid    = 3'd0;
        elapsed_mid = 10'd0;
      end
      tps_pkg::ACT_TICK: begin
        if (busy) begin
          if (!(pat_ok(current_pattern) &&
                step_number < tps_pkg::pat_len(current_pattern))) begin
            busy_mid    = 1'b0;
            pattern_mid = 3'd0;
            step_mid    = 3'd0;
            elapsed_mid = 10'd0;
          end else if (el_inc >= tps_pkg::step_ms(idx)) begin
            if (sn_inc >= {1'b0, tps_pkg::pat_len(current_pattern)}) begin
              busy_mid    = 1'b0;
              pattern_mid = 3'd0;
              step_mid    = 3'd0;
            end else begin
              step_mid = sn_inc[2:0];
            end
            elapsed_mid = 10'd0;
          end else begin
            elapsed_mid = el_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // a busy flag with no playable step means the pattern is over
  always_comb begin
    busy_next            = busy_mid;
    current_pattern_next = pattern_mid;
    step_number_next     = step_mid;
    step_elapsed_ms_next = elapsed_mid;
    if (busy_mid && !(pat_ok(pattern_mid) && step_mid < tps_pkg::pat_len(pattern_mid))) begin
      busy_next            = 1'b0;
      current_pattern_next = 3'd0;
      step_number_next     = 3'd0;
      step_elapsed_ms_next = 10'd0;
    end
  end

  always_comb begin
    result.playing = busy_next;
    result.tone_hz = busy_next ?
        tps_pkg::step_freq(tps_pkg::pat_off(current_pattern_next) +
                           {2'b00, step_number_next}) : 12'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      current_pattern <= 3'd0;
      step_number     <= 3'd0;
      step_elapsed_ms <= 10'd0;
    end else if (fire) begin
      busy            <= busy_next;
      current_pattern <= current_pattern_next;
      step_number     <= step_number_next;
      step_elapsed_ms <= step_elapsed_ms_next;
    end
  end

endmodule

### rtl/tps_checker.sv
// port-level checker for the tone pattern sequencer and its bind
module tps_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [11:0] rsp_tone_hz,
  input logic        rsp_playing
);

  // nothing comes out in the cycle after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // a sounding tone only while a pattern plays
  a_tone_playing: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_tone_hz != 12'd0 |-> rsp_playing)
    else $error("tone without a playing pattern");

  // only frequencies from the pattern table appear
  a_tone_table: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_tone_hz == 12'd0 || rsp_tone_hz == 12'd500 ||
                   rsp_tone_hz == 12'd600 || rsp_tone_hz == 12'd800 ||
                   rsp_tone_hz == 12'd900 || rsp_tone_hz == 12'd1000 ||
                   rsp_tone_hz == 12'd1200 || rsp_tone_hz == 12'd4000))
    else $error("tone not in pattern table");

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tone_hz) && $stable(rsp_playing))
    else $error("stalled result changed");

  // an item accepted while no result is held shows a result after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
    else $error("result missing after accepted item");

endmodule

bind tone_pattern_sequencer tps_checker u_tps_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_tone_hz(rsp.tone_hz),
  .rsp_playing(rsp.playing)
);
